// ===== sv/mtee_pkg.sv =====
// Package for the MIDI track event encoder: field widths, request codes,
// byte constants and the job record passed from front end to back end.
// No dependencies.
`default_nettype none

package mtee_pkg;

    localparam int TICK_WIDTH_DEF = 32;
    localparam int TICKS_W        = 32;
    localparam int LEN_W          = 28;
    localparam int REQ_W          = 2;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [REQ_W-1:0] REQ_HDR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DATA = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EOT  = 2'd2;

    localparam logic [LEN_W-1:0] VLQ_MAX = 28'h0FFFFFFF;

    localparam logic [7:0] BYTE_META  = 8'hFF;
    localparam logic [7:0] STATUS_BIT = 8'h80;
    localparam logic [7:0] SYSEX_F0   = 8'hF0;
    localparam logic [7:0] SYSEX_F7   = 8'hF7;
    localparam logic [7:0] META_EOT   = 8'h2F;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;

    typedef enum logic [1:0] {
        K_EVENT,
        K_DATA,
        K_EOT
    } t_kind;

    typedef enum logic [1:0] {
        F_META,
        F_SYSEX,
        F_VOICE_ST,
        F_VOICE_RS
    } t_form;

    // lead_byte: status/meta type for events, the byte itself for data
    typedef struct packed {
        t_kind            kind;
        t_form            form;
        logic [7:0]       lead_byte;
        logic [LEN_W-1:0] delta;
        logic [LEN_W-1:0] length;
    } t_job;

endpackage

`default_nettype wire

// ===== sv/mtee_if.sv =====
// Valid/ready channel interfaces for requests in and body bytes out.
// Depends on mtee_pkg.
`default_nettype none

interface mtee_in_if;
    logic                            valid;
    logic                            ready;
    logic [mtee_pkg::REQ_W-1:0]      req_type;
    logic [mtee_pkg::TICKS_W-1:0]    event_ticks;
    logic [7:0]                      status;
    logic [mtee_pkg::LEN_W-1:0]      payload_len;
    logic [7:0]                      data_byte;

    modport source (output valid, req_type, event_ticks, status, payload_len, data_byte,
                    input ready);
    modport sink   (input valid, req_type, event_ticks, status, payload_len, data_byte,
                    output ready);
endinterface

interface mtee_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic        track_done;
    logic [31:0] body_length;

    modport source (output valid, out_byte, last_of_run, track_done, body_length,
                    input ready);
    modport sink   (input valid, out_byte, last_of_run, track_done, body_length,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/mtee_front.sv =====
// Front end: accepts requests, tracks tick/running status/drop state and
// pushes one job per request that produces bytes. Depends on mtee_pkg, mtee_if.
`default_nettype none

module mtee_front #(
    parameter int TICK_WIDTH = mtee_pkg::TICK_WIDTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    mtee_in_if.sink         i_evt,
    input  wire logic       i_q_full,
    output logic            o_push,
    output mtee_pkg::t_job  o_job
);

    logic [TICK_WIDTH-1:0]        r_last_tick, n_last_tick;
    logic [7:0]                   r_run_st, n_run_st;
    logic                         r_drop, n_drop;

    logic [TICK_WIDTH-1:0]        ticks;
    logic [TICK_WIDTH-1:0]        diff;
    logic [mtee_pkg::LEN_W-1:0]   diff_sat;
    logic                         later;
    logic                         accept;

    generate
        if (TICK_WIDTH <= mtee_pkg::TICKS_W) begin : g_tick_cut
            assign ticks = i_evt.event_ticks[TICK_WIDTH-1:0];
        end else begin : g_tick_ext
            assign ticks = {{(TICK_WIDTH-mtee_pkg::TICKS_W){1'b0}}, i_evt.event_ticks};
        end

        if (TICK_WIDTH > mtee_pkg::LEN_W) begin : g_sat
            assign diff_sat = (|diff[TICK_WIDTH-1:mtee_pkg::LEN_W]) ?
                              mtee_pkg::VLQ_MAX : diff[mtee_pkg::LEN_W-1:0];
        end else if (TICK_WIDTH == mtee_pkg::LEN_W) begin : g_same
            assign diff_sat = diff;
        end else begin : g_pad
            assign diff_sat = {{(mtee_pkg::LEN_W-TICK_WIDTH){1'b0}}, diff};
        end
    endgenerate

    assign later       = ticks > r_last_tick;
    assign diff        = ticks - r_last_tick;
    assign i_evt.ready = !i_q_full;
    assign accept      = i_evt.valid && !i_q_full;

    always_comb begin
        n_last_tick     = r_last_tick;
        n_run_st        = r_run_st;
        n_drop          = r_drop;
        o_push          = 1'b0;
        o_job.kind      = mtee_pkg::K_EVENT;
        o_job.form      = mtee_pkg::F_VOICE_RS;
        o_job.lead_byte = i_evt.status;
        o_job.delta     = later ? diff_sat : '0;
        o_job.length    = i_evt.payload_len;

        unique case (i_evt.req_type)
            mtee_pkg::REQ_HDR: begin
                if (later) begin
                    n_last_tick = ticks;
                end
                if (i_evt.status == mtee_pkg::META_EOT) begin
                    // end-of-track meta: swallow it and its data
                    n_drop = 1'b1;
                end else begin
                    n_drop = 1'b0;
                    o_push = 1'b1;
                    if (i_evt.status < mtee_pkg::STATUS_BIT) begin
                        o_job.form = mtee_pkg::F_META;
                        n_run_st   = '0;
                    end else if (i_evt.status == mtee_pkg::SYSEX_F0 ||
                                 i_evt.status == mtee_pkg::SYSEX_F7) begin
                        o_job.form = mtee_pkg::F_SYSEX;
                        n_run_st   = '0;
                    end else begin
                        o_job.form = (r_run_st != i_evt.status) ?
                                     mtee_pkg::F_VOICE_ST : mtee_pkg::F_VOICE_RS;
                        n_run_st   = i_evt.status;
                    end
                end
            end
            mtee_pkg::REQ_DATA: begin
                o_job.kind      = mtee_pkg::K_DATA;
                o_job.lead_byte = i_evt.data_byte;
                o_push          = !r_drop;
            end
            mtee_pkg::REQ_EOT: begin
                o_job.kind  = mtee_pkg::K_EOT;
                o_push      = 1'b1;
                n_last_tick = '0;
                n_run_st    = '0;
                n_drop      = 1'b0;
            end
            default: begin
            end
        endcase

        if (!accept) begin
            o_push      = 1'b0;
            n_last_tick = r_last_tick;
            n_run_st    = r_run_st;
            n_drop      = r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_tick <= '0;
            r_run_st    <= '0;
            r_drop      <= 1'b0;
        end else begin
            r_last_tick <= n_last_tick;
            r_run_st    <= n_run_st;
            r_drop      <= n_drop;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mtee_queue.sv =====
// Four-entry job queue between front and back end, register based.
// Depends on mtee_pkg.
`default_nettype none

module mtee_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire mtee_pkg::t_job  i_job,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output mtee_pkg::t_job       o_head
);

    mtee_pkg::t_job                r_slot [mtee_pkg::Q_DEPTH];
    logic [mtee_pkg::Q_PTR_W-1:0]  r_wr, r_rd;
    logic [mtee_pkg::Q_CNT_W-1:0]  r_cnt;
    logic                          do_push, do_pop;

    assign o_full  = r_cnt == mtee_pkg::Q_CNT_W'(mtee_pkg::Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mtee_back.sv =====
// Back end: expands the head job into body bytes, one per cycle while not stalled,
// via a registered output stage; counts body bytes. Depends on mtee_pkg, mtee_if.
`default_nettype none

module mtee_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_empty,
    input  wire mtee_pkg::t_job  i_head,
    output logic                 o_pop,
    mtee_out_if.source           o_byte
);

    typedef enum logic [2:0] {
        PH_DELTA,
        PH_FF,
        PH_ST,
        PH_LEN,
        PH_DATA,
        PH_EOT
    } t_phase;

    t_phase       r_phase, n_phase, cur_phase;
    logic [1:0]   r_grp, n_grp, cur_grp;
    logic         r_mid;
    logic [31:0]  r_count;
    logic         r_valid;
    logic [7:0]   r_byte;
    logic         r_last;
    logic         r_done;
    logic [31:0]  r_blen;

    logic         load_ok, emit;
    logic [7:0]   cur_byte;
    logic         cur_last, cur_done;

    function automatic logic [1:0] vlq_top(input logic [mtee_pkg::LEN_W-1:0] v);
        logic [1:0] g;
        if (|v[27:21])      g = 2'd3;
        else if (|v[20:14]) g = 2'd2;
        else if (|v[13:7])  g = 2'd1;
        else                g = 2'd0;
        return g;
    endfunction

    function automatic logic [7:0] vlq_byte(input logic [mtee_pkg::LEN_W-1:0] v,
                                            input logic [1:0] g);
        logic [7:0] b;
        case (g)
            2'd0:    b = {1'b0, v[6:0]};
            2'd1:    b = {1'b1, v[13:7]};
            2'd2:    b = {1'b1, v[20:14]};
            default: b = {1'b1, v[27:21]};
        endcase
        return b;
    endfunction

    assign load_ok = !r_valid || o_byte.ready;
    assign emit    = load_ok && !i_q_empty;
    assign o_pop   = emit && cur_last;

    always_comb begin
        if (r_mid) begin
            cur_phase = r_phase;
            cur_grp   = r_grp;
        end else begin
            unique case (i_head.kind)
                mtee_pkg::K_EVENT: begin
                    cur_phase = PH_DELTA;
                    cur_grp   = vlq_top(i_head.delta);
                end
                mtee_pkg::K_DATA: begin
                    cur_phase = PH_DATA;
                    cur_grp   = 2'd0;
                end
                default: begin
                    cur_phase = PH_EOT;
                    cur_grp   = 2'd3;
                end
            endcase
        end

        cur_byte = mtee_pkg::BYTE_ZERO;
        cur_last = 1'b0;
        cur_done = 1'b0;
        n_phase  = cur_phase;
        n_grp    = cur_grp - 1'b1;

        unique case (cur_phase)
            PH_DELTA: begin
                cur_byte = vlq_byte(i_head.delta, cur_grp);
                if (cur_grp == 2'd0) begin
                    unique case (i_head.form)
                        mtee_pkg::F_META:     n_phase = PH_FF;
                        mtee_pkg::F_SYSEX:    n_phase = PH_ST;
                        mtee_pkg::F_VOICE_ST: n_phase = PH_ST;
                        default:              cur_last = 1'b1;
                    endcase
                end
            end
            PH_FF: begin
                cur_byte = mtee_pkg::BYTE_META;
                n_phase  = PH_ST;
            end
            PH_ST: begin
                cur_byte = i_head.lead_byte;
                if (i_head.form == mtee_pkg::F_VOICE_ST) begin
                    cur_last = 1'b1;
                end else begin
                    n_phase = PH_LEN;
                    n_grp   = vlq_top(i_head.length);
                end
            end
            PH_LEN: begin
                cur_byte = vlq_byte(i_head.length, cur_grp);
                cur_last = cur_grp == 2'd0;
            end
            PH_DATA: begin
                cur_byte = i_head.lead_byte;
                cur_last = 1'b1;
            end
            default: begin
                // end marker 00 FF 2F 00
                case (cur_grp)
                    2'd2:    cur_byte = mtee_pkg::BYTE_META;
                    2'd1:    cur_byte = mtee_pkg::META_EOT;
                    default: cur_byte = mtee_pkg::BYTE_ZERO;
                endcase
                cur_last = cur_grp == 2'd0;
                cur_done = cur_grp == 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid   <= 1'b0;
            r_phase <= PH_DELTA;
            r_grp   <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load_ok) begin
                r_valid <= !i_q_empty;
            end
            if (emit) begin
                r_mid   <= !cur_last;
                r_phase <= n_phase;
                r_grp   <= n_grp;
                r_count <= cur_done ? '0 : r_count + 1'b1;
                r_byte  <= cur_byte;
                r_last  <= cur_last;
                r_done  <= cur_done;
                r_blen  <= cur_done ? r_count + 1'b1 : '0;
            end
        end
    end

    assign o_byte.valid       = r_valid;
    assign o_byte.out_byte    = r_byte;
    assign o_byte.last_of_run = r_last;
    assign o_byte.track_done  = r_done;
    assign o_byte.body_length = r_blen;

endmodule

`default_nettype wire

// ===== sv/midi_track_event_encoder_unit.sv =====
// Top level of the MIDI track event encoder: front end, job queue, back end.
// Depends on mtee_pkg, mtee_if, mtee_front, mtee_queue, mtee_back.
//
//  Port     Dir  Carries                                        Transfer
//  -------  ---  ---------------------------------------------  ------------------
//  i_evt    in   req_type, event_ticks, status, payload_len,    valid && ready
//                data_byte (one request per transfer)
//  o_byte   out  out_byte, last_of_run, track_done, body_length valid && ready
//
// The front end takes one request per cycle while its 4-entry job queue has room.
// The back end emits one body byte per cycle while o_byte is not stalled: a data
// request gives 1 byte, an event header 1 to 10 bytes (delta VLQ plus form bytes),
// end of track 4 bytes; the one-byte output register sets the sustained rate.
// Reset is synchronous, active low; it clears tick, running status, drop flag,
// byte count, queue pointers and output valid. No clearing pass.
// A stall on o_byte holds the output register and backs up into the queue;
// i_evt.ready falls only when the queue is full.
`default_nettype none

module midi_track_event_encoder_unit #(
    parameter int TICK_WIDTH = mtee_pkg::TICK_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mtee_in_if.sink     i_evt,
    mtee_out_if.source  o_byte
);

    logic            push, pop, q_full, q_empty;
    mtee_pkg::t_job  push_job, head_job;

    // request classification and per-track state
    mtee_front #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_evt    (i_evt),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    // decouples request intake from byte output
    mtee_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    // byte sequencer and body length counter
    mtee_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (head_job),
        .o_pop     (pop),
        .o_byte    (o_byte)
    );

endmodule

`default_nettype wire

// ===== sv/mtee_checker.sv =====
// Port-level checks for the MIDI track event encoder, bound to the top level.
// Depends on mtee_if and midi_track_event_encoder_unit.
`default_nettype none

module mtee_checker (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    mtee_out_if.source  o_byte
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_byte.valid && !o_byte.ready |=> o_byte.valid && $stable(o_byte.out_byte))
        else $error("output request changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_byte.valid)
        else $error("output valid after reset");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_byte.valid && o_byte.track_done |-> o_byte.last_of_run && o_byte.out_byte == 8'h00)
        else $error("track done on wrong byte");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_byte.valid && !o_byte.track_done |-> o_byte.body_length == 32'd0)
        else $error("body length outside track done");

    a_len_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_byte.valid && o_byte.track_done |-> o_byte.body_length != 32'd0)
        else $error("zero body length on track done");

endmodule

bind midi_track_event_encoder_unit mtee_checker u_mtee_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_byte  (o_byte)
);

`default_nettype wire
